/* hdl/plti_pkg.sv */
`default_nettype none

package plti_pkg;

   // fixed field widths
   localparam int VALUE_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 6;
   localparam int COUNT_WIDTH  = 7;
   localparam int DIV_WIDTH    = VALUE_WIDTH + 1;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(2);

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_LOW  = 2'd1,
      CLAMP_HIGH = 2'd2
   } clamp_type;

   typedef enum logic [1:0] {
      ADDR_FIRST = 2'd0,
      ADDR_LAST  = 2'd1,
      ADDR_MID   = 2'd2
   } addr_sel_type;

   typedef struct packed {
      cmd_type                         cmd;
      logic [INDEX_WIDTH-1:0]          point_index;
      logic signed [VALUE_WIDTH-1:0]   point_x;
      logic signed [VALUE_WIDTH-1:0]   point_y;
      logic signed [VALUE_WIDTH-1:0]   query_x;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]   value_y;
      clamp_type                       clamp_status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic          idle;
      addr_sel_type  addr_sel;
      logic          take_lo;
      logic          take_hi;
      logic          probe_update;
      logic          div_start;
      logic          div_step;
      logic          res_load;
      clamp_type     res_status;
      logic          load_rsp;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic query_start;
      logic query_le_rd;
      logic query_ge_rd;
      logic search_done;
      logic div_last;
      logic rsp_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

/* hdl/plti_ram.sv */
`default_nettype none

module plti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/plti_ctrl.sv */
`default_nettype none

module plti_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plti_pkg::ctl_sts_type sts,
   output plti_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_FIRST  = 8'b0000_0010,
      S_LAST   = 8'b0000_0100,
      S_SEARCH = 8'b0000_1000,
      S_PROBE  = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_FIN    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.addr_sel     = plti_pkg::ADDR_FIRST;
      cmd.res_status   = plti_pkg::CLAMP_NONE;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.query_start) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (sts.query_le_rd) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = plti_pkg::CLAMP_LOW;
               state_in       = S_OUT;
            end else begin
               cmd.take_lo  = 1'b1;
               cmd.addr_sel = plti_pkg::ADDR_LAST;
               state_in     = S_LAST;
            end
         end
         S_LAST: begin
            if (sts.query_ge_rd) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = plti_pkg::CLAMP_HIGH;
               state_in       = S_OUT;
            end else begin
               cmd.take_hi = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (sts.search_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.addr_sel = plti_pkg::ADDR_MID;
               state_in     = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe_update = 1'b1;
            state_in         = S_SEARCH;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = plti_pkg::CLAMP_NONE;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/plti_dp.sv */
`default_nettype none

module plti_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire plti_pkg::ctl_cmd_type                    cmd,
   output plti_pkg::ctl_sts_type                         sts,
   input  wire logic                                     req_valid,
   input  wire plti_pkg::req_type                        req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output plti_pkg::rsp_type                             rsp_data,
   input  wire logic                                     csr_valid,
   input  wire logic [plti_pkg::COUNT_WIDTH-1:0]         csr_data,
   output logic                                          ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]                ram_wr_addr,
   output logic [2*plti_pkg::VALUE_WIDTH-1:0]            ram_wr_data,
   output logic [$clog2(TABLE_DEPTH)-1:0]                ram_rd_addr,
   input  wire logic [2*plti_pkg::VALUE_WIDTH-1:0]       ram_rd_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int VW = plti_pkg::VALUE_WIDTH;
   localparam int DW = plti_pkg::DIV_WIDTH;
   localparam int CW = plti_pkg::DIV_CNT_WIDTH;

   logic [plti_pkg::COUNT_WIDTH-1:0] count_ff;

   logic signed [VW-1:0] query_ff;
   logic [AW-1:0]        lo_idx_ff, hi_idx_ff;
   logic signed [VW-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;

   logic [VW-1:0]        span_ff, dx_ff;
   logic                 neg_ff;
   logic [VW-1:0]        div_r_ff;
   logic [DW-1:0]        div_q_ff, div_b_ff;
   logic [CW-1:0]        div_cnt_ff;

   logic signed [VW-1:0] res_ff;
   plti_pkg::clamp_type  res_status_ff;
   logic                 rsp_valid_ff;
   plti_pkg::rsp_type    rsp_data_ff;

   logic                 accept;
   logic [31:0]          idx_w;
   logic [31:0]          n_w;
   logic [31:0]          last_w;
   logic [AW-1:0]        last_idx;
   logic [AW:0]          mid_sum;
   logic [AW-1:0]        mid_idx;
   logic [AW-1:0]        idx_diff;
   logic signed [VW-1:0] rd_x, rd_y;

   logic [VW:0]          span_w, dx_w, dy_w, mag_w;
   logic [VW+1:0]        div_t, div_m1, div_m2;
   logic                 ge1, ge2;
   logic [VW+1:0]        div_r_wide;
   logic [VW-1:0]        div_r_in;
   logic [DW-1:0]        div_q_in;
   logic [VW:0]          res_wide;
   logic signed [VW-1:0] res_in;

   // input side
   assign accept = req_valid & cmd.idle;
   assign idx_w  = 32'(req_data.point_index);

   assign ram_wr_en   = accept & (req_data.cmd == plti_pkg::CMD_LOAD)
                        & (idx_w < 32'(TABLE_DEPTH));
   assign ram_wr_addr = idx_w[AW-1:0];
   assign ram_wr_data = {req_data.point_x, req_data.point_y};

   // count clamped into range 2..TABLE_DEPTH
   always_comb begin
      n_w = 32'(count_ff);
      if (n_w < 32'd2) begin
         n_w = 32'd2;
      end
      if (n_w > 32'(TABLE_DEPTH)) begin
         n_w = 32'(TABLE_DEPTH);
      end
   end
   assign last_w   = n_w - 32'd1;
   assign last_idx = last_w[AW-1:0];

   assign mid_sum  = {1'b0, lo_idx_ff} + {1'b0, hi_idx_ff};
   assign mid_idx  = mid_sum[AW:1];
   assign idx_diff = hi_idx_ff - lo_idx_ff;

   always_comb begin
      case (cmd.addr_sel)
         plti_pkg::ADDR_FIRST: ram_rd_addr = '0;
         plti_pkg::ADDR_LAST:  ram_rd_addr = last_idx;
         plti_pkg::ADDR_MID:   ram_rd_addr = mid_idx;
         default:              ram_rd_addr = '0;
      endcase
   end

   assign rd_x = ram_rd_data[2*VW-1:VW];
   assign rd_y = ram_rd_data[VW-1:0];

   // operand prep for the divide
   assign span_w = {hi_x_ff[VW-1], hi_x_ff} - {lo_x_ff[VW-1], lo_x_ff};
   assign dx_w   = {query_ff[VW-1], query_ff} - {lo_x_ff[VW-1], lo_x_ff};
   assign dy_w   = {hi_y_ff[VW-1], hi_y_ff} - {lo_y_ff[VW-1], lo_y_ff};
   assign mag_w  = dy_w[VW] ? (~dy_w + (VW+1)'(1)) : dy_w;

   // one multiplier bit per step: r = 2r + a*bit, reduced by up to 2m
   assign div_t  = {1'b0, div_r_ff, 1'b0} + (div_b_ff[DW-1] ? {2'b00, dx_ff} : '0);
   assign div_m1 = {2'b00, span_ff};
   assign div_m2 = {1'b0, span_ff, 1'b0};
   assign ge2    = div_t >= div_m2;
   assign ge1    = div_t >= div_m1;

   always_comb begin
      if (ge2) begin
         div_r_wide = div_t - div_m2;
      end else if (ge1) begin
         div_r_wide = div_t - div_m1;
      end else begin
         div_r_wide = div_t;
      end
   end
   assign div_r_in = div_r_wide[VW-1:0];
   assign div_q_in = {div_q_ff[DW-2:0], 1'b0} + DW'({ge2, ge1 & ~ge2});

   // result lies between the two y values, so truncation is exact
   assign res_wide = neg_ff ? ({lo_y_ff[VW-1], lo_y_ff} - div_q_ff)
                            : ({lo_y_ff[VW-1], lo_y_ff} + div_q_ff);
   assign res_in   = (cmd.res_status == plti_pkg::CLAMP_NONE) ? res_wide[VW-1:0] : rd_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= plti_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_data.cmd == plti_pkg::CMD_QUERY)) begin
         query_ff <= req_data.query_x;
      end
      if (cmd.take_lo) begin
         lo_idx_ff <= '0;
         lo_x_ff   <= rd_x;
         lo_y_ff   <= rd_y;
      end
      if (cmd.take_hi) begin
         hi_idx_ff <= last_idx;
         hi_x_ff   <= rd_x;
         hi_y_ff   <= rd_y;
      end
      if (cmd.probe_update) begin
         if (rd_x < query_ff) begin
            lo_idx_ff <= mid_idx;
            lo_x_ff   <= rd_x;
            lo_y_ff   <= rd_y;
         end else begin
            hi_idx_ff <= mid_idx;
            hi_x_ff   <= rd_x;
            hi_y_ff   <= rd_y;
         end
      end
      if (cmd.div_start) begin
         span_ff    <= span_w[VW-1:0];
         dx_ff      <= dx_w[VW-1:0];
         neg_ff     <= dy_w[VW];
         div_b_ff   <= mag_w;
         div_r_ff   <= '0;
         div_q_ff   <= '0;
         div_cnt_ff <= CW'(DW - 1);
      end
      if (cmd.div_step) begin
         div_r_ff   <= div_r_in;
         div_q_ff   <= div_q_in;
         div_b_ff   <= {div_b_ff[DW-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff - CW'(1);
      end
      if (cmd.res_load) begin
         res_ff        <= res_in;
         res_status_ff <= cmd.res_status;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.value_y      <= res_ff;
         rsp_data_ff.clamp_status <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.query_start = accept & (req_data.cmd == plti_pkg::CMD_QUERY);
   assign sts.query_le_rd = query_ff <= rd_x;
   assign sts.query_ge_rd = query_ff >= rd_x;
   assign sts.search_done = idx_diff <= AW'(1);
   assign sts.div_last    = div_cnt_ff == '0;
   assign sts.rsp_free    = ~rsp_valid_ff | ~rsp_stall;

endmodule

`default_nettype wire

/* hdl/piecewise_linear_table_interp.sv */
// piecewise linear interpolation over a breakpoint table of (x, y) pairs
// req channel (req_valid, req_stall, req_data): a load word writes one breakpoint
//   into the table ram; a query word asks for y at query_x
// rsp channel (rsp_valid, rsp_stall, rsp_data): one word per query, none per load
// csr channel (csr_valid, csr_ready, csr_data): number of breakpoints in use,
//   always ready; the user writes it only while the block is idle (not enforced)
// loads are taken one per cycle while no query is in flight
// a query at or below the first x answers with the first y, flagged clamp low;
//   at or above the last x, with the last y, flagged clamp high; an interpolated
//   query runs a bracketing search, each probe on the single registered ram read
//   port, then a shift-subtract multiply-divide, one multiplier bit per cycle
// one query is in flight at a time; req_stall is high from query accept until
// its result sits in the output register
// a held result waits in the output register while rsp_stall is high; the next
// word is still accepted, but its result waits in the block until that slot frees
// reset clears control state and sets the point count to 2; table contents
// are left as they were and must be loaded before use
`default_nettype none

module piecewise_linear_table_interp #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request words
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire plti_pkg::req_type                     req_data,
   // response words
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output plti_pkg::rsp_type                          rsp_data,
   // point count register
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [plti_pkg::COUNT_WIDTH-1:0]      csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int RAM_WIDTH = 2 * plti_pkg::VALUE_WIDTH;

   plti_pkg::ctl_cmd_type  cmd;
   plti_pkg::ctl_sts_type  sts;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [RAM_WIDTH-1:0]   ram_wr_data;
   logic [AW-1:0]          ram_rd_addr;
   logic [RAM_WIDTH-1:0]   ram_rd_data;

   // requests only enter while the sequencer is idle
   assign req_stall = ~cmd.idle;
   assign csr_ready = 1'b1;

   // sequencer: edge clamps, bracketing search, divide, output hand-off
   plti_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // search bounds, serial multiply-divide and output register
   plti_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // breakpoint table, x in the upper half and y in the lower half of each entry
   plti_ram #(
      .WIDTH (RAM_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
